[rtl/clr_pkg.sv]
`default_nettype none

package clr_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int MAX_ITER_DEF    = 100;

    // Field widths fixed by the interface
    localparam int DW  = 32;   // Q16.16 data
    localparam int ITW = 7;    // iteration count
    localparam int STW = 2;    // status code
    localparam int RIW = 2;    // register index

    // Divider geometry
    localparam int DIVW  = 64;
    localparam int DIVHW = 32;
    localparam int DCW   = $clog2(DIVW + 1);

    typedef enum logic [1:0] {
        M_BISECT = 2'd0,
        M_NEWTON = 2'd1,
        M_FISHER = 2'd2,
        M_SECANT = 2'd3
    } t_method;

    typedef enum logic [STW-1:0] {
        ST_CONV    = 2'd0,
        ST_NOCONV  = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_OVF     = 2'd3
    } t_status;

    typedef enum logic [RIW-1:0] {
        REG_METHOD  = 2'd0,
        REG_START_A = 2'd1,
        REG_START_B = 2'd2,
        REG_TOL     = 2'd3
    } t_reg_idx;

    localparam logic signed [DW-1:0] START_A_RST = 32'sh0000_0000;
    localparam logic signed [DW-1:0] START_B_RST = 32'sh0001_0000;
    localparam logic [DW-2:0]        TOL_RST     = 31'd66;

    typedef struct packed {
        logic signed [DW-1:0] sample;
        logic                 last;
    } t_in_beat;

    typedef struct packed {
        logic signed [DW-1:0] estimate;
        logic [ITW-1:0]       iterations;
        logic [STW-1:0]       status;
    } t_out_beat;

    // Divider request and response
    typedef struct packed {
        logic            start;
        logic            half;   // quotient known to fit in DIVHW bits
        logic [DIVW-1:0] num;
        logic [DIVW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

`default_nettype wire

[rtl/clr_div.sv]
`default_nettype none

module clr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  clr_pkg::t_div_req           i_req,
    output clr_pkg::t_div_rsp           o_rsp,
    output logic [clr_pkg::DIVW-1:0]    o_quo
);
    import clr_pkg::*;

    logic [DIVW-1:0] r_rem;
    logic [DIVW-1:0] r_num;
    logic [DIVW-1:0] r_den;
    logic [DCW-1:0]  r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DIVW:0]   w_trial;
    logic [DIVW:0]   w_sub;
    logic            w_ge;

    // One restoring step per cycle
    assign w_trial = {r_rem, r_num[DIVW-1]};
    assign w_sub   = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.half ? DCW'(DIVHW) : DCW'(DIVW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCW'(1);
                if (r_cnt == DCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath; half mode starts with the upper word already in the remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            if (i_req.half) begin
                r_rem <= {{(DIVW-DIVHW){1'b0}}, i_req.num[DIVW-1:DIVW-DIVHW]};
                r_num <= {i_req.num[DIVW-DIVHW-1:0], {DIVHW{1'b0}}};
            end else begin
                r_rem <= '0;
                r_num <= i_req.num;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DIVW-1:0] : w_trial[DIVW-1:0];
            r_num <= {r_num[DIVW-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quo      = r_num;

endmodule

`default_nettype wire

[rtl/cauchy_location_root_finder.sv]
`default_nettype none

// Channel   | Direction | Handshake                  | Beat
// ----------+-----------+----------------------------+------------------------------
// in        | input     | i_in_valid / o_in_ready    | t_in_beat (sample, last)
// out       | output    | o_out_valid / i_out_ready  | t_out_beat (estimate, iter, status)
// cfg       | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// Loading takes one beat per cycle into the sample memory while in is ready.
// Each score evaluation passes over every stored sample, using the shared 32-step
// divider to form 1/(1+d^2) for each; bisection and secant evaluate twice per
// iteration, Newton and Fisher once; all but bisection add a 64-step division.
// Reset is synchronous, active low; no clearing pass, the fill count bounds reads.
// in is not ready during a solve or while a result waits and out is stalled.
module cauchy_location_root_finder #(
    parameter int MAX_SAMPLES = clr_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_ITER    = clr_pkg::MAX_ITER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  clr_pkg::t_in_beat          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output clr_pkg::t_out_beat         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [clr_pkg::RIW-1:0]    i_cfg_idx,
    input  logic [clr_pkg::DW-1:0]     i_cfg_data
);
    import clr_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = DW + CW;      // score accumulator
    localparam int HW = DW + 3 + CW;  // derivative accumulator

    typedef enum logic [16:0] {
        S_LOAD  = 17'h00001,
        S_SETUP = 17'h00002,
        S_E_RD  = 17'h00004,
        S_E_D   = 17'h00008,
        S_E_M   = 17'h00010,
        S_E_U   = 17'h00020,
        S_E_DIV = 17'h00040,
        S_E_T   = 17'h00080,
        S_E_UU  = 17'h00100,
        S_E_H   = 17'h00200,
        S_E_END = 17'h00400,
        S_NEXT  = 17'h00800,
        S_MUL   = 17'h01000,
        S_SDIV  = 17'h02000,
        S_QDIV  = 17'h04000,
        S_CHECK = 17'h08000,
        S_DONE  = 17'h10000
    } t_state;

    function automatic logic signed [DW-1:0] sat35(input logic signed [DW+2:0] v);
        logic hi_same;
        hi_same = (&v[DW+2:DW-1]) || !(|v[DW+2:DW-1]);
        if (hi_same) return v[DW-1:0];
        return v[DW+2] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    function automatic logic signed [DW-1:0] mid(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        return s[DW:1];
    endfunction

    t_state               r_state;
    t_method              r_method;
    logic signed [DW-1:0] r_start_a;
    logic signed [DW-1:0] r_start_b;
    logic [DW-2:0]        r_tol;

    logic [CW-1:0]        r_count;
    logic                 r_ovf;
    logic [CW-1:0]        r_idx;
    logic                 r_pass;
    logic [ITW-1:0]       r_iter;
    logic [STW-1:0]       r_status;

    logic signed [DW-1:0] r_low, r_high, r_x, r_prev, r_theta, r_nx;
    logic signed [DW-1:0] r_sx, r_s2;
    logic signed [SW-1:0] r_sacc;
    logic signed [HW-1:0] r_hacc;
    logic                 r_dneg;
    logic [DW-1:0]        r_m;
    logic [2*DW-1:0]      r_prod;
    logic                 r_qneg;
    logic [DW:0]          r_den;

    logic [DW-1:0]        r_mem [MAX_SAMPLES];
    logic signed [DW-1:0] r_rd;

    t_out_beat            r_out;
    logic                 r_out_valid;

    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;
    logic [DIVW-1:0]      w_quo;

    logic                 w_in_acc;
    logic                 w_full;
    logic                 w_ovf_out;
    logic                 w_out_set;
    logic signed [DW-1:0] w_d;
    logic [DW-1:0]        w_u;
    logic [DW-1:0]        w_t;
    logic signed [DW+1:0] w_hterm;
    logic signed [SW:0]   w_s2x;
    logic signed [DW-1:0] w_score;
    logic [DW-1:0]        w_sxmag;
    logic [HW:0]          w_hmag;
    logic signed [DW:0]   w_diff;
    logic [DW-1:0]        w_diffmag;
    logic signed [DW:0]   w_sden;
    logic [DW-1:0]        w_mul_a, w_mul_b;
    logic signed [DW-1:0] w_qv;
    logic signed [DW+1:0] w_qf;
    logic signed [DW-1:0] w_qnx;
    logic signed [DW:0]   w_step;
    logic [DW:0]          w_stepmag;
    logic [ITW-1:0]       w_iter_nx;
    logic                 w_bis_high;
    logic signed [DW-1:0] w_bis_nx;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_full   = (r_count >= CW'(MAX_SAMPLES));
    assign o_in_ready  = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Last beat of an overflowed set answers at once
    assign w_ovf_out = (r_state == S_LOAD) && w_in_acc && i_in_data.last && (r_ovf || w_full);
    assign w_out_set = w_ovf_out || (r_state == S_DONE);

    // Per-sample terms
    assign w_d     = sat35({{3{r_rd[DW-1]}}, r_rd} - {{3{r_theta[DW-1]}}, r_theta});
    assign w_u     = w_quo[DW-1:0];
    assign w_t     = r_prod[2*DW-1:DW];
    assign w_hterm = $signed({2'b00, w_u}) - $signed({1'b0, r_prod[2*DW-1:DW-1]});

    // Score = 2*sum, saturated
    assign w_s2x   = {r_sacc, 1'b0};
    assign w_score = ((&w_s2x[SW:DW-1]) || !(|w_s2x[SW:DW-1])) ? w_s2x[DW-1:0] :
                     (w_s2x[SW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

    // Step operands
    assign w_sxmag   = r_sx[DW-1] ? DW'(-r_sx) : r_sx;
    assign w_hmag    = r_hacc[HW-1] ? (HW+1)'(-{r_hacc, 1'b0}) : {r_hacc, 1'b0};
    assign w_diff    = {r_x[DW-1], r_x} - {r_prev[DW-1], r_prev};
    assign w_diffmag = w_diff[DW] ? DW'(-w_diff) : w_diff[DW-1:0];
    assign w_sden    = {r_sx[DW-1], r_sx} - {r_s2[DW-1], r_s2};

    // Bisection update
    assign w_bis_high = (r_s2 == '0) || (r_sx == '0) || (r_s2[DW-1] != r_sx[DW-1]);
    assign w_bis_nx   = w_bis_high ? mid(r_low, r_x) : mid(r_x, r_high);

    // Quotient to next point
    always_comb begin
        if (r_qneg) begin
            w_qv = (w_quo >= DIVW'(64'h8000_0000)) ? {1'b1, {(DW-1){1'b0}}}
                                                   : DW'(-w_quo[DW-1:0]);
            w_qf = -$signed({1'b0, w_quo[DW:0]});
        end else begin
            w_qv = (w_quo > DIVW'(64'h7FFF_FFFF)) ? {1'b0, {(DW-1){1'b1}}} : w_quo[DW-1:0];
            w_qf = $signed({1'b0, w_quo[DW:0]});
        end
        if (r_method == M_FISHER) begin
            w_qnx = sat35({{3{r_x[DW-1]}}, r_x} + {w_qf[DW+1], w_qf});
        end else begin
            w_qnx = sat35({{3{r_x[DW-1]}}, r_x} - {{3{w_qv[DW-1]}}, w_qv});
        end
    end

    assign w_step    = {r_nx[DW-1], r_nx} - {r_x[DW-1], r_x};
    assign w_stepmag = w_step[DW] ? (DW+1)'(-w_step) : w_step;
    assign w_iter_nx = r_iter + ITW'(1);

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_E_T:   begin w_mul_a = r_m;     w_mul_b = w_u;       end
            S_E_UU:  begin w_mul_a = w_u;     w_mul_b = w_u;       end
            S_MUL:   begin w_mul_a = w_sxmag; w_mul_b = w_diffmag; end
            default: begin w_mul_a = r_m;     w_mul_b = r_m;       end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {{DW{1'b0}}, w_mul_a} * {{DW{1'b0}}, w_mul_b};
    end

    // Divider requests
    always_comb begin
        w_div_req       = '0;
        w_div_req.start = 1'b0;
        case (r_state)
            S_E_U: begin
                w_div_req.start = 1'b1;
                w_div_req.half  = 1'b1;
                w_div_req.num   = '1;
                w_div_req.den   = DIVW'(64'h1_0000_0000) + r_prod;
            end
            S_NEXT: begin
                if (r_method == M_NEWTON) begin
                    w_div_req.start = (r_hacc != '0);
                    w_div_req.num   = {w_sxmag, {DW{1'b0}}};
                    w_div_req.den   = {{(DIVW-HW-1){1'b0}}, w_hmag};
                end else if (r_method == M_FISHER) begin
                    w_div_req.start = (r_count != '0);
                    w_div_req.num   = {{(DIVW-DW-1){1'b0}}, w_sxmag, 1'b0};
                    w_div_req.den   = {{(DIVW-CW){1'b0}}, r_count};
                end
            end
            S_SDIV: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = r_prod;
                w_div_req.den   = {{(DIVW-DW-1){1'b0}}, r_den};
            end
            default: ;
        endcase
    end

    clr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp),
        .o_quo   (w_quo)
    );

    // Sample memory
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_full) begin
            r_mem[r_count[AW-1:0]] <= i_in_data.sample;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method  <= M_BISECT;
            r_start_a <= START_A_RST;
            r_start_b <= START_B_RST;
            r_tol     <= TOL_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_METHOD:  r_method  <= t_method'(i_cfg_data[1:0]);
                REG_START_A: r_start_a <= i_cfg_data;
                REG_START_B: r_start_b <= i_cfg_data;
                REG_TOL:     r_tol     <= i_cfg_data[DW-2:0];
                default: ;
            endcase
        end
    end

    // Result valid: set by a new result, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_set) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_iter      <= '0;
            r_idx       <= '0;
            r_pass      <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_ovf_out) begin
                        r_out.estimate   <= '0;
                        r_out.iterations <= '0;
                        r_out.status     <= ST_OVF;
                        r_count          <= '0;
                        r_ovf            <= 1'b0;
                    end else if (w_in_acc) begin
                        if (w_full) r_ovf <= 1'b1;
                        else        r_count <= r_count + CW'(1);
                        if (i_in_data.last) r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    unique case (r_method)
                        M_BISECT: begin
                            r_low   <= r_start_a;
                            r_high  <= r_start_b;
                            r_x     <= mid(r_start_a, r_start_b);
                            r_theta <= mid(r_start_a, r_start_b);
                        end
                        M_SECANT: begin
                            r_prev  <= r_start_a;
                            r_x     <= r_start_b;
                            r_theta <= r_start_b;
                        end
                        default: begin
                            r_x     <= r_start_a;
                            r_theta <= r_start_a;
                        end
                    endcase
                    r_iter  <= ITW'(1);
                    r_pass  <= 1'b0;
                    r_idx   <= '0;
                    r_sacc  <= '0;
                    r_hacc  <= '0;
                    r_state <= S_E_RD;
                end
                S_E_RD:  r_state <= S_E_D;
                S_E_D: begin
                    r_dneg  <= w_d[DW-1];
                    r_m     <= w_d[DW-1] ? DW'(-w_d) : w_d;
                    r_state <= S_E_M;
                end
                S_E_M:   r_state <= S_E_U;
                S_E_U:   r_state <= S_E_DIV;
                S_E_DIV: if (w_div_rsp.done) r_state <= S_E_T;
                S_E_T:   r_state <= S_E_UU;
                S_E_UU: begin
                    r_sacc  <= r_dneg ? r_sacc - $signed({{(SW-DW){1'b0}}, w_t})
                                      : r_sacc + $signed({{(SW-DW){1'b0}}, w_t});
                    r_state <= S_E_H;
                end
                S_E_H: begin
                    r_hacc  <= r_hacc + {{(HW-DW-2){w_hterm[DW+1]}}, w_hterm};
                    r_idx   <= r_idx + CW'(1);
                    r_state <= (r_idx + CW'(1) < r_count) ? S_E_RD : S_E_END;
                end
                S_E_END: begin
                    if (!r_pass) begin
                        r_sx <= w_score;
                        if (r_method == M_BISECT || r_method == M_SECANT) begin
                            r_pass  <= 1'b1;
                            r_theta <= (r_method == M_BISECT) ? r_low : r_prev;
                            r_idx   <= '0;
                            r_sacc  <= '0;
                            r_hacc  <= '0;
                            r_state <= S_E_RD;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_s2    <= w_score;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    unique case (r_method)
                        M_BISECT: begin
                            if (w_bis_high) r_high <= r_x;
                            else            r_low  <= r_x;
                            r_nx    <= w_bis_nx;
                            r_state <= S_CHECK;
                        end
                        M_NEWTON: begin
                            r_qneg <= r_sx[DW-1] ^ r_hacc[HW-1];
                            if (r_hacc == '0) begin
                                r_status <= ST_DIVZERO;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_QDIV;
                            end
                        end
                        M_FISHER: begin
                            r_qneg <= r_sx[DW-1];
                            if (r_count == '0) begin
                                r_status <= ST_DIVZERO;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_QDIV;
                            end
                        end
                        default: begin
                            r_qneg <= r_sx[DW-1] ^ w_diff[DW] ^ w_sden[DW];
                            r_den  <= w_sden[DW] ? (DW+1)'(-w_sden) : w_sden;
                            if (w_sden == '0) begin
                                r_status <= ST_DIVZERO;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                    endcase
                end
                S_MUL:  r_state <= S_SDIV;
                S_SDIV: r_state <= S_QDIV;
                S_QDIV: begin
                    if (w_div_rsp.done) begin
                        r_nx    <= w_qnx;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_stepmag < {2'b00, r_tol}) begin
                        r_status <= ST_CONV;
                        r_state  <= S_DONE;
                    end else begin
                        r_iter <= w_iter_nx;
                        if (w_iter_nx >= ITW'(MAX_ITER)) begin
                            r_status <= ST_NOCONV;
                            r_state  <= S_DONE;
                        end else begin
                            if (r_method == M_SECANT) r_prev <= r_x;
                            r_x     <= r_nx;
                            r_theta <= r_nx;
                            r_pass  <= 1'b0;
                            r_idx   <= '0;
                            r_sacc  <= '0;
                            r_hacc  <= '0;
                            r_state <= S_E_RD;
                        end
                    end
                end
                S_DONE: begin
                    r_out.estimate   <= r_x;
                    r_out.iterations <= r_iter;
                    r_out.status     <= r_status;
                    r_count          <= '0;
                    r_ovf            <= 1'b0;
                    r_state          <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_iter_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= ITW'(MAX_ITER))
        else $error("iteration count beyond limit");

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("fill count beyond memory depth");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_valid)
        else $error("finished solve produced no result");

    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_RD) |-> (r_idx < r_count))
        else $error("read beyond filled entries");
`endif

endmodule

`default_nettype wire
